[design/hld_pkg.sv]
// Shared types, codes and saturating helpers for the luma edge deblocking core.
// Depends on nothing; the core refers to it by scoped names.
package hld_pkg;

  typedef logic [7:0] samp_t;
  // Index 0 is p3 (bits 7:0) up through index 7, q3 (bits 63:56).
  typedef samp_t [7:0] line_t;
  // Wide enough for any sample sum or difference used by the filters.
  typedef logic signed [10:0] sw_t;
  // Accumulator for the normal-filter offset before its divide by 16.
  typedef logic signed [13:0] acc_t;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_STRONG = 2'd2
  } mode_t;

  localparam int unsigned P3 = 0;
  localparam int unsigned P2 = 1;
  localparam int unsigned P1 = 2;
  localparam int unsigned P0 = 3;
  localparam int unsigned Q0 = 4;
  localparam int unsigned Q1 = 5;
  localparam int unsigned Q2 = 6;
  localparam int unsigned Q3 = 7;

  localparam acc_t DELTA_EDGE_GAIN  = 14'sd9;
  localparam acc_t DELTA_INNER_GAIN = 14'sd3;
  localparam acc_t DELTA_ROUND      = 14'sd8;
  localparam sw_t  SKIP_GAIN        = 11'sd10;
  localparam sw_t  SAMP_MAX         = 11'sd255;

  function automatic sw_t ext(samp_t s);
    return sw_t'({3'b000, s});
  endfunction

  function automatic sw_t abs_s(sw_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic sw_t clip_s(sw_t lo, sw_t hi, sw_t v);
    sw_t r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

  function automatic samp_t sat8(sw_t v);
    samp_t r;
    r = v[7:0];
    if (v < 0) r = '0;
    if (v > SAMP_MAX) r = '1;
    return r;
  endfunction

endpackage

[design/hevc_luma_edge_deblock_core.sv]
// Three-stage luma deblocking core: activity measures, filter decision, sample update.
// Depends on hld_pkg for sample types, mode codes and saturating helpers.

// One 4-line edge segment enters per cycle while in_ready is high and leaves, filtered,
// from stage three; sustained rate is one segment per clock while out_ready stays high.
// Stage one measures the second differences, flatness and edge step of lines 0 and 3
// and forms the strong-filter averages and the raw normal-filter offset of every line;
// stage two decides the mode, clips the offsets and the strong results; stage three
// applies the p1/q1 side correction and picks the output per mode. Each stage holds a
// valid bit and takes a new word whenever it is empty or its successor moves, so in_ready
// follows out_ready through that chain and bubbles close up while the output waits.
module hevc_luma_edge_deblock_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] line_zero,
  input  logic [63:0] line_one,
  input  logic [63:0] line_two,
  input  logic [63:0] line_three,
  input  logic [4:0]  clip_limit,
  input  logic [6:0]  activity_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_line_zero,
  output logic [63:0] out_line_one,
  output logic [63:0] out_line_two,
  output logic [63:0] out_line_three,
  output logic [1:0]  filter_mode
);

  typedef struct packed {
    hld_pkg::line_t [3:0]                 line;
    logic [4:0]                           tc;
    logic [6:0]                           beta;
    logic [8:0]                           dp0;
    logic [8:0]                           dq0;
    logic [8:0]                           dp3;
    logic [8:0]                           dq3;
    logic [1:0][8:0]                      flat;   // |p3-p0|+|q0-q3|, lines 0 and 3
    logic [1:0][7:0]                      step;   // |p0-q0|, lines 0 and 3
    hld_pkg::sw_t [3:0]                   delta;
    logic [3:0][5:0][7:0]                 savg;   // strong averages for p2..q2
  } s1_t;

  typedef struct packed {
    hld_pkg::line_t [3:0]                 line;
    hld_pkg::mode_t                       mode;
    logic                                 p_side;
    logic                                 q_side;
    logic [3:0]                           tc_half;
    logic [3:0]                           skip;
    hld_pkg::sw_t [3:0]                   dclip;
    logic [3:0][7:0]                      np0;
    logic [3:0][7:0]                      nq0;
    logic [3:0][5:0][7:0]                 sval;
  } s2_t;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  s1_t  s1, s1_next;
  s2_t  s2, s2_next;
  hld_pkg::line_t [3:0] res_next;
  hld_pkg::mode_t       mode_q;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3;
  assign filter_mode = mode_q;

  function automatic logic [11:0] z12(hld_pkg::samp_t s);
    return {4'b0000, s};
  endfunction

  // Stage one: per-line measures and strong averages.
  always_comb begin
    hld_pkg::line_t x;
    hld_pkg::sw_t   dp_v, dq_v;
    hld_pkg::acc_t  acc;
    logic [11:0]    sum;
    s1_next = '0;
    s1_next.line[0] = hld_pkg::line_t'(line_zero);
    s1_next.line[1] = hld_pkg::line_t'(line_one);
    s1_next.line[2] = hld_pkg::line_t'(line_two);
    s1_next.line[3] = hld_pkg::line_t'(line_three);
    s1_next.tc   = clip_limit;
    s1_next.beta = activity_limit;
    for (int l = 0; l < 4; l++) begin
      x = s1_next.line[l];
      dp_v = hld_pkg::abs_s(hld_pkg::ext(x[hld_pkg::P2]) - (hld_pkg::ext(x[hld_pkg::P1]) <<< 1)
                            + hld_pkg::ext(x[hld_pkg::P0]));
      dq_v = hld_pkg::abs_s(hld_pkg::ext(x[hld_pkg::Q2]) - (hld_pkg::ext(x[hld_pkg::Q1]) <<< 1)
                            + hld_pkg::ext(x[hld_pkg::Q0]));
      if (l == 0) begin
        s1_next.dp0 = dp_v[8:0];
        s1_next.dq0 = dq_v[8:0];
      end
      if (l == 3) begin
        s1_next.dp3 = dp_v[8:0];
        s1_next.dq3 = dq_v[8:0];
      end
      if (l == 0 || l == 3) begin
        s1_next.flat[l / 3] = 9'(hld_pkg::abs_s(hld_pkg::ext(x[hld_pkg::P3])
                                                - hld_pkg::ext(x[hld_pkg::P0]))
                                 + hld_pkg::abs_s(hld_pkg::ext(x[hld_pkg::Q0])
                                                  - hld_pkg::ext(x[hld_pkg::Q3])));
        s1_next.step[l / 3] = 8'(hld_pkg::abs_s(hld_pkg::ext(x[hld_pkg::P0])
                                                - hld_pkg::ext(x[hld_pkg::Q0])));
      end
      acc = hld_pkg::DELTA_EDGE_GAIN
              * hld_pkg::acc_t'(hld_pkg::ext(x[hld_pkg::Q0]) - hld_pkg::ext(x[hld_pkg::P0]))
          - hld_pkg::DELTA_INNER_GAIN
              * hld_pkg::acc_t'(hld_pkg::ext(x[hld_pkg::Q1]) - hld_pkg::ext(x[hld_pkg::P1]))
          + hld_pkg::DELTA_ROUND;
      s1_next.delta[l] = hld_pkg::sw_t'(acc >>> 4);

      sum = z12(x[hld_pkg::P2]) + (z12(x[hld_pkg::P1]) << 1) + (z12(x[hld_pkg::P0]) << 1)
          + (z12(x[hld_pkg::Q0]) << 1) + z12(x[hld_pkg::Q1]) + 12'd4;
      s1_next.savg[l][2] = sum[10:3];
      sum = z12(x[hld_pkg::P2]) + z12(x[hld_pkg::P1]) + z12(x[hld_pkg::P0])
          + z12(x[hld_pkg::Q0]) + 12'd2;
      s1_next.savg[l][1] = sum[9:2];
      sum = (z12(x[hld_pkg::P3]) << 1) + 12'd3 * z12(x[hld_pkg::P2]) + z12(x[hld_pkg::P1])
          + z12(x[hld_pkg::P0]) + z12(x[hld_pkg::Q0]) + 12'd4;
      s1_next.savg[l][0] = sum[10:3];
      sum = z12(x[hld_pkg::Q2]) + (z12(x[hld_pkg::Q1]) << 1) + (z12(x[hld_pkg::Q0]) << 1)
          + (z12(x[hld_pkg::P0]) << 1) + z12(x[hld_pkg::P1]) + 12'd4;
      s1_next.savg[l][3] = sum[10:3];
      sum = z12(x[hld_pkg::Q2]) + z12(x[hld_pkg::Q1]) + z12(x[hld_pkg::Q0])
          + z12(x[hld_pkg::P0]) + 12'd2;
      s1_next.savg[l][4] = sum[9:2];
      sum = (z12(x[hld_pkg::Q3]) << 1) + 12'd3 * z12(x[hld_pkg::Q2]) + z12(x[hld_pkg::Q1])
          + z12(x[hld_pkg::Q0]) + z12(x[hld_pkg::P0]) + 12'd4;
      s1_next.savg[l][5] = sum[10:3];
    end
  end

  // Stage two: mode decision, side and skip flags, delta clip, new p0/q0, strong clip.
  always_comb begin
    logic [10:0]   dsum;
    logic [10:0]   act [2];
    logic [7:0]    step_lim;
    logic [8:0]    side_lim;
    logic          strong_ok;
    hld_pkg::sw_t  tc_s, t2, lim, d;
    hld_pkg::samp_t xs;
    s2_next = '0;
    s2_next.line = s1.line;
    dsum = {2'b00, s1.dp0} + {2'b00, s1.dq0} + {2'b00, s1.dp3} + {2'b00, s1.dq3};
    act[0] = ({2'b00, s1.dp0} + {2'b00, s1.dq0}) << 1;
    act[1] = ({2'b00, s1.dp3} + {2'b00, s1.dq3}) << 1;
    step_lim = 8'(({3'b000, s1.tc} * 8'd5 + 8'd1) >> 1);
    side_lim = 9'(({2'b00, s1.beta} * 9'd3) >> 4);
    strong_ok = 1'b1;
    for (int k = 0; k < 2; k++) begin
      if (!(act[k] < {6'b0, s1.beta[6:2]}))       strong_ok = 1'b0;
      if (!(s1.flat[k] < {5'b0, s1.beta[6:3]}))   strong_ok = 1'b0;
      if (!(s1.step[k] < step_lim))               strong_ok = 1'b0;
    end
    if (!(dsum < {4'b0000, s1.beta})) begin
      s2_next.mode = hld_pkg::MODE_NONE;
    end else if (strong_ok) begin
      s2_next.mode = hld_pkg::MODE_STRONG;
    end else begin
      s2_next.mode = hld_pkg::MODE_NORMAL;
    end
    s2_next.p_side  = ({1'b0, s1.dp0} + {1'b0, s1.dp3}) < {1'b0, side_lim};
    s2_next.q_side  = ({1'b0, s1.dq0} + {1'b0, s1.dq3}) < {1'b0, side_lim};
    s2_next.tc_half = s1.tc[4:1];
    tc_s = hld_pkg::sw_t'({6'b0, s1.tc});
    t2   = tc_s <<< 1;
    lim  = hld_pkg::SKIP_GAIN * tc_s;
    for (int l = 0; l < 4; l++) begin
      s2_next.skip[l]  = !(hld_pkg::abs_s(s1.delta[l]) < lim);
      d = hld_pkg::clip_s(-tc_s, tc_s, s1.delta[l]);
      s2_next.dclip[l] = d;
      s2_next.np0[l] = hld_pkg::sat8(hld_pkg::ext(s1.line[l][hld_pkg::P0]) + d);
      s2_next.nq0[l] = hld_pkg::sat8(hld_pkg::ext(s1.line[l][hld_pkg::Q0]) - d);
      for (int i = 0; i < 6; i++) begin
        xs = s1.line[l][i + 1];
        s2_next.sval[l][i] = hld_pkg::sat8(hld_pkg::clip_s(hld_pkg::ext(xs) - t2,
                                                           hld_pkg::ext(xs) + t2,
                                                           hld_pkg::ext(s1.savg[l][i])));
      end
    end
  end

  // Stage three: side correction and output select.
  always_comb begin
    hld_pkg::line_t x;
    hld_pkg::sw_t   th, a, t;
    hld_pkg::samp_t np1, nq1;
    th = hld_pkg::sw_t'({7'b0, s2.tc_half});
    for (int l = 0; l < 4; l++) begin
      x = s2.line[l];
      a = (hld_pkg::ext(x[hld_pkg::P2]) + hld_pkg::ext(x[hld_pkg::P0]) + 11'sd1) >>> 1;
      t = (a - hld_pkg::ext(x[hld_pkg::P1]) + s2.dclip[l]) >>> 1;
      np1 = hld_pkg::sat8(hld_pkg::ext(x[hld_pkg::P1]) + hld_pkg::clip_s(-th, th, t));
      a = (hld_pkg::ext(x[hld_pkg::Q2]) + hld_pkg::ext(x[hld_pkg::Q0]) + 11'sd1) >>> 1;
      t = (a - hld_pkg::ext(x[hld_pkg::Q1]) - s2.dclip[l]) >>> 1;
      nq1 = hld_pkg::sat8(hld_pkg::ext(x[hld_pkg::Q1]) + hld_pkg::clip_s(-th, th, t));
      res_next[l] = x;
      case (s2.mode)
        hld_pkg::MODE_STRONG: begin
          for (int i = 0; i < 6; i++) res_next[l][i + 1] = s2.sval[l][i];
        end
        hld_pkg::MODE_NORMAL: begin
          if (!s2.skip[l]) begin
            res_next[l][hld_pkg::P0] = s2.np0[l];
            res_next[l][hld_pkg::Q0] = s2.nq0[l];
            if (s2.p_side) res_next[l][hld_pkg::P1] = np1;
            if (s2.q_side) res_next[l][hld_pkg::Q1] = nq1;
          end
        end
        default: begin
          res_next[l] = x;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Payload advances with its valid bit; hold while the next stage cannot take it.
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) s1 <= s1_next;
    if (rdy2 && v1)       s2 <= s2_next;
    if (rdy3 && v2) begin
      out_line_zero  <= res_next[0];
      out_line_one   <= res_next[1];
      out_line_two   <= res_next[2];
      out_line_three <= res_next[3];
      mode_q         <= s2.mode;
    end
  end

  // A word in a stage with an empty successor always moves on.
  a_s1_moves: assert property (@(posedge clk) disable iff (rst)
    (v1 && !v2) |=> v2)
    else $error("stage one word did not advance into empty stage two");

  a_s2_moves: assert property (@(posedge clk) disable iff (rst)
    (v2 && !v3) |=> v3)
    else $error("stage two word did not advance into empty output stage");

  a_none_passes: assert property (@(posedge clk) disable iff (rst)
    (v2 && rdy3 && s2.mode == hld_pkg::MODE_NONE) |=>
      (out_line_zero == $past(s2.line[0]) && out_line_three == $past(s2.line[3])))
    else $error("unfiltered segment changed");

  a_strong_keeps_outer: assert property (@(posedge clk) disable iff (rst)
    (v2 && rdy3 && s2.mode == hld_pkg::MODE_STRONG) |=>
      (out_line_one[7:0] == $past(s2.line[1][hld_pkg::P3]) &&
       out_line_one[63:56] == $past(s2.line[1][hld_pkg::Q3])))
    else $error("strong filter touched p3 or q3");

endmodule
